// File: design/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg
// Types and codes shared by the interrupt subscriber mailbox files.
// ----------------------------------------------------------------------------
`default_nettype none

package ism_pkg;

  typedef enum logic [2:0] {
    OP_BIND   = 3'd0,
    OP_UNBIND = 3'd1,
    OP_PUSH   = 3'd2,
    OP_SIGNAL = 3'd3,
    OP_READ   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_NOTIFY = 2'd2,
    KIND_WAKE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_BUSY     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_AGAIN    = 3'd4,
    ST_WAITING  = 3'd5
  } status_t;

  // At most this many results leave for one request.
  localparam int unsigned RESULT_CAP = 16;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  line;
    logic [7:0]  owner_id;
    logic        wants_notify;
    logic [31:0] notify_bits;
    logic [7:0]  data_byte;
    logic [4:0]  read_count;
    logic        blocking;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [1:0]  slot;
    logic [7:0]  slot_owner;
    logic [7:0]  byte_out;
    logic [31:0] bits_out;
    logic [4:0]  bytes_read;
    logic        line_enabled;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/ism_if.sv
// ----------------------------------------------------------------------------
// ism_in_if / ism_out_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ism_in_if;
  logic               valid;
  logic               ready;
  ism_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ism_out_if;
  logic               valid;
  logic               ready;
  ism_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/ism_ram.sv
// ----------------------------------------------------------------------------
// ism_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/irq_subscriber_mailbox.sv
// ----------------------------------------------------------------------------
// irq_subscriber_mailbox
// Per-line subscriber slots with byte rings, notify and waiter wakeup.
// ----------------------------------------------------------------------------
// Each interrupt line owns SLOTS_PER_LINE subscriber slots. A slot record
// (owner, notify flag, signal bits, ring head and tail, wait flag) lives in
// a record RAM, and the ring bytes live in a second RAM; only the bound flag
// of each slot is kept in flip-flops so that reset frees every slot at once.
// Requests are handled one at a time. Every slot that a request looks at
// is read from the record RAM in S_LOOK, then checked and written back in
// S_CHK. Bind, unbind and a read lookup scan the slots of the line in order
// until one fits, then issue their results; push and signal visit every slot
// of the line, issue a wakeup or notify result for each slot that asks for
// one, then the closing status. An invalid request goes straight to its status.
// A read fetches each byte in S_RRD and returns it in S_RDAT because the ring
// RAM has one registered read port. A new request is taken once the previous
// one has issued its last result into the output register, even while that
// result still waits to be taken. A state that issues a result waits while
// the output register holds a result that has not yet been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module irq_subscriber_mailbox #(
  parameter int unsigned LINE_COUNT     = 16,
  parameter int unsigned SLOTS_PER_LINE = 4,
  parameter int unsigned RING_DEPTH     = 64,
  parameter int unsigned MAX_READ       = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ism_in_if.sink     in_chan,
  ism_out_if.source  out_chan
);

  import ism_pkg::*;

  localparam int unsigned NSLOTS = LINE_COUNT * SLOTS_PER_LINE;
  localparam int unsigned SW     = (SLOTS_PER_LINE > 1) ? $clog2(SLOTS_PER_LINE) : 1;
  localparam int unsigned LW     = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int unsigned IW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int unsigned PW     = $clog2(RING_DEPTH);
  localparam int unsigned RDEPTH = NSLOTS * RING_DEPTH;
  localparam int unsigned RAW    = $clog2(RDEPTH);
  localparam int unsigned RW     = 8 + 1 + 32 + PW + PW + 1;
  localparam int unsigned RD_CAP = (MAX_READ < RESULT_CAP) ? MAX_READ : RESULT_CAP;

  // Record layout, low to high: wait, tail, head, bits, notify, owner.
  localparam int unsigned TAIL_LO = 1;
  localparam int unsigned HEAD_LO = 1 + PW;
  localparam int unsigned BITS_LO = 1 + 2 * PW;
  localparam int unsigned NOTE_B  = 33 + 2 * PW;
  localparam int unsigned OWN_LO  = 34 + 2 * PW;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_CHK, S_WAKE, S_NOTE, S_STAT, S_EMPTY, S_RRD, S_RDAT
  } state_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t              state_r;
  logic [NSLOTS-1:0]   bound_r;
  logic [2:0]          op_r;
  logic [LW-1:0]       line_r;
  logic [7:0]          owner_r;
  logic                wn_r;
  logic [31:0]         bits_r;
  logic [7:0]          byte_r;
  logic [4:0]          want_r;
  logic                blk_r;
  logic                inv_r;
  logic [SW-1:0]       s_r;
  logic [4:0]          cnt_r;
  logic [4:0]          nread_r;
  logic [2:0]          stat_r;
  logic [SW-1:0]       stat_slot_r;
  logic [7:0]          stat_own_r;
  logic [7:0]          rown_r;
  logic                rnote_r;
  logic [31:0]         rbits_r;
  logic [PW-1:0]       rhead_r;
  logic [PW-1:0]       rtail_r;
  logic                rwait_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  // RAM ports
  logic                rec_we, rec_re;
  logic [IW-1:0]       rec_waddr;
  logic [RW-1:0]       rec_wdata, rec_rdata;
  logic                ring_we, ring_re;
  logic [RAW-1:0]      ring_waddr, ring_raddr;
  logic [7:0]          ring_rdata;

  ism_ram #(.WIDTH(RW), .DEPTH(NSLOTS)) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .re(rec_re), .raddr(rec_waddr), .rdata(rec_rdata)
  );

  ism_ram #(.WIDTH(8), .DEPTH(RDEPTH)) u_ring_ram (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(byte_r),
    .re(ring_re), .raddr(ring_raddr), .rdata(ring_rdata)
  );

  // Fields of the record just read.
  logic [7:0]    rd_own;
  logic          rd_note;
  logic [31:0]   rd_bits;
  logic [PW-1:0] rd_head, rd_tail, head_new;
  logic          rd_wait;
  logic [IW-1:0] cur_idx;
  logic          cur_bound, cur_match, ring_full, line_any, out_free;
  logic          is_fire, last_slot, rd_done;
  logic [PW-1:0] tail_new;

  assign rd_own   = rec_rdata[OWN_LO +: 8];
  assign rd_note  = rec_rdata[NOTE_B];
  assign rd_bits  = rec_rdata[BITS_LO +: 32];
  assign rd_head  = rec_rdata[HEAD_LO +: PW];
  assign rd_tail  = rec_rdata[TAIL_LO +: PW];
  assign rd_wait  = rec_rdata[0];
  assign head_new = ptr_inc(rd_head);
  assign tail_new = ptr_inc(rtail_r);

  assign cur_idx   = IW'(int'(line_r) * SLOTS_PER_LINE + int'(s_r));
  assign cur_bound = bound_r[cur_idx];
  assign cur_match = cur_bound && (rd_own == owner_r);
  assign ring_full = (head_new == rd_tail);
  assign is_fire   = (op_r == OP_PUSH) || (op_r == OP_SIGNAL);
  assign last_slot = (s_r == SW'(SLOTS_PER_LINE - 1));
  assign rd_done   = (nread_r + 5'd1 == want_r) || (tail_new == rhead_r);
  assign out_free  = !out_valid_r || out_chan.ready;

  always_comb begin
    line_any = 1'b0;
    for (int k = 0; k < SLOTS_PER_LINE; k++) begin
      if (bound_r[IW'(int'(line_r) * SLOTS_PER_LINE + k)]) begin
        line_any = 1'b1;
      end
    end
  end

  // Memory control: records are read in S_LOOK and written back in S_CHK,
  // or at the end of a read; ring bytes are written during a push.
  always_comb begin
    rec_re     = (state_r == S_LOOK);
    rec_waddr  = cur_idx;
    rec_we     = 1'b0;
    rec_wdata  = {rd_own, rd_note, rd_bits, rd_head, rd_tail, 1'b0};
    ring_we    = 1'b0;
    ring_re    = (state_r == S_RRD);
    ring_waddr = RAW'(int'(cur_idx) * RING_DEPTH + int'(rd_head));
    ring_raddr = RAW'(int'(cur_idx) * RING_DEPTH + int'(rtail_r));
    unique case (state_r)
      S_CHK: begin
        if (op_r == OP_BIND) begin
          if (!cur_bound) begin
            rec_we    = 1'b1;
            rec_wdata = {owner_r, wn_r, bits_r, {PW{1'b0}}, {PW{1'b0}}, 1'b0};
          end
        end else if (op_r == OP_UNBIND) begin
          if (cur_match) begin
            rec_we    = 1'b1;
            rec_wdata = '0;
          end
        end else if (is_fire) begin
          if (cur_bound) begin
            rec_we = 1'b1;
            if (op_r == OP_PUSH && !ring_full) begin
              ring_we   = 1'b1;
              rec_wdata = {rd_own, rd_note, rd_bits, head_new, rd_tail, 1'b0};
            end
          end
        end
      end
      S_EMPTY: begin
        rec_we    = out_free && blk_r;
        rec_wdata = {rown_r, rnote_r, rbits_r, rhead_r, rtail_r, 1'b1};
      end
      S_RDAT: begin
        rec_we    = out_free && rd_done;
        rec_wdata = {rown_r, rnote_r, rbits_r, rhead_r, tail_new, rwait_r};
      end
      default: begin
      end
    endcase
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Result builder; results past the cap are dropped and the one at the cap
  // carries last.
  function automatic out_item_t mk(
    input logic [1:0] kind, input logic [2:0] st, input logic [SW-1:0] sl,
    input logic [7:0] own, input logic [7:0] b, input logic [31:0] bits,
    input logic [4:0] nr, input logic en, input logic fin, input logic [4:0] cnt
  );
    out_item_t o;
    o.kind         = kind;
    o.status       = st;
    o.slot         = 2'(sl);
    o.slot_owner   = own;
    o.byte_out     = b;
    o.bits_out     = bits;
    o.bytes_read   = nr;
    o.line_enabled = en;
    o.last         = fin || (cnt == 5'(RESULT_CAP - 1));
    mk = o;
  endfunction

  logic en_now;
  assign en_now = !inv_r && line_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bound_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r        <= in_chan.data.opcode;
            line_r      <= LW'(in_chan.data.line);
            owner_r     <= in_chan.data.owner_id;
            wn_r        <= in_chan.data.wants_notify;
            bits_r      <= in_chan.data.notify_bits;
            byte_r      <= in_chan.data.data_byte;
            want_r      <= (in_chan.data.read_count > 5'(RD_CAP)) ? 5'(RD_CAP)
                                                               : in_chan.data.read_count;
            blk_r       <= in_chan.data.blocking;
            s_r         <= '0;
            cnt_r       <= '0;
            nread_r     <= '0;
            stat_r      <= ST_OK;
            stat_slot_r <= '0;
            stat_own_r  <= '0;
            if ({1'b0, in_chan.data.line} >= 9'(LINE_COUNT) ||
                in_chan.data.opcode > OP_READ ||
                (in_chan.data.opcode == OP_READ && in_chan.data.read_count == 5'd0)) begin
              inv_r   <= 1'b1;
              stat_r  <= ST_INVALID;
              state_r <= S_STAT;
            end else begin
              inv_r   <= 1'b0;
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          rown_r  <= rd_own;
          rnote_r <= rd_note;
          rbits_r <= rd_bits;
          rhead_r <= rd_head;
          rtail_r <= rd_tail;
          rwait_r <= rd_wait;
          if (op_r == OP_BIND) begin
            if (cur_match) begin
              stat_r  <= ST_BUSY;
              state_r <= S_STAT;
            end else if (!cur_bound) begin
              bound_r[cur_idx] <= 1'b1;
              stat_slot_r      <= s_r;
              stat_own_r       <= owner_r;
              state_r          <= S_STAT;
            end else if (last_slot) begin
              stat_r  <= ST_BUSY;
              state_r <= S_STAT;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_LOOK;
            end
          end else if (op_r == OP_UNBIND || op_r == OP_READ) begin
            if (cur_match) begin
              if (op_r == OP_UNBIND) begin
                bound_r[cur_idx] <= 1'b0;
                stat_slot_r      <= s_r;
                stat_own_r       <= owner_r;
                state_r          <= rd_wait ? S_WAKE : S_STAT;
              end else begin
                state_r <= (rd_head == rd_tail) ? S_EMPTY : S_RRD;
              end
            end else if (last_slot) begin
              stat_r  <= ST_NOTFOUND;
              state_r <= S_STAT;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_LOOK;
            end
          end else begin
            // Push or signal: visit every slot of the line in order.
            if (cur_bound && rd_wait) begin
              state_r <= S_WAKE;
            end else if (cur_bound && rd_note) begin
              state_r <= S_NOTE;
            end else if (last_slot) begin
              state_r <= S_STAT;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_LOOK;
            end
          end
        end
        S_WAKE: begin
          if (out_free) begin
            if (cnt_r < 5'(RESULT_CAP)) begin
              out_valid_r <= 1'b1;
              out_data_r  <= mk(KIND_WAKE, ST_OK, s_r, rown_r, 8'd0, 32'd0, 5'd0,
                                en_now, 1'b0, cnt_r);
              cnt_r       <= cnt_r + 5'd1;
            end
            if (op_r == OP_UNBIND) begin
              state_r <= S_STAT;
            end else if (rnote_r) begin
              state_r <= S_NOTE;
            end else if (last_slot) begin
              state_r <= S_STAT;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_LOOK;
            end
          end
        end
        S_NOTE: begin
          if (out_free) begin
            if (cnt_r < 5'(RESULT_CAP)) begin
              out_valid_r <= 1'b1;
              out_data_r  <= mk(KIND_NOTIFY, ST_OK, s_r, rown_r, 8'd0, rbits_r, 5'd0,
                                en_now, 1'b0, cnt_r);
              cnt_r       <= cnt_r + 5'd1;
            end
            if (last_slot) begin
              state_r <= S_STAT;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_LOOK;
            end
          end
        end
        S_STAT: begin
          if (out_free) begin
            if (cnt_r < 5'(RESULT_CAP)) begin
              out_valid_r <= 1'b1;
              out_data_r  <= mk(KIND_STATUS, stat_r, stat_slot_r, stat_own_r, 8'd0,
                                32'd0, 5'd0, en_now, 1'b1, cnt_r);
            end
            state_r <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= mk(KIND_STATUS, blk_r ? ST_WAITING : ST_AGAIN, s_r, owner_r,
                              8'd0, 32'd0, 5'd0, en_now, 1'b1, cnt_r);
            state_r     <= S_IDLE;
          end
        end
        S_RRD: begin
          state_r <= S_RDAT;
        end
        S_RDAT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= mk(KIND_DATA, ST_OK, s_r, owner_r, ring_rdata, 32'd0,
                              nread_r + 5'd1, en_now, rd_done, cnt_r);
            cnt_r       <= cnt_r + 5'd1;
            nread_r     <= nread_r + 5'd1;
            rtail_r     <= tail_new;
            state_r     <= rd_done ? S_IDLE : S_RRD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
